### sv/qte_pkg.sv
// qte_pkg: shared widths, types, constants and helper functions for the
// quaternion to euler angles block. Depends on nothing.
`default_nettype none
package qte_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN    = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > ATAN_TABLE_LEN) ?
                                     ATAN_TABLE_LEN : CORDIC_ITERATIONS;
  localparam int FRONT_STAGES      = 4;
  localparam int SQRT_STEPS        = 31;
  localparam int PIPE_DEPTH        = FRONT_STAGES + SQRT_STEPS + 1 + CORDIC_STEPS;

  localparam int CW  = 37;  // cordic x/y width
  localparam int AW  = 34;  // q30 angle width
  localparam int SQW = 62;  // square root datapath width

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t             PI_Q30        = 34'sd3373259426;
  localparam logic signed [32:0] HALF_Q30    = 33'sd536870912;
  localparam logic [14:0]      PITCH_MAX_Q13 = 15'd12868;
  localparam logic [14:0]      ANGLE_MAX_Q13 = 15'd25736;

  typedef struct packed {
    logic signed [33:0] sp;
    logic               clamped;
    logic signed [32:0] yaw_n;
    logic signed [32:0] yaw_x;
    logic signed [32:0] roll_n;
    logic signed [32:0] roll_x;
  } pass_t;

  typedef struct packed {
    logic clamped;
    logic neg;
  } pflag_t;

  function automatic ang_t atan_q30(input logic [4:0] i);
    ang_t r;
    case (i)
      5'd0:    r = 34'sh03243F6A8;
      5'd1:    r = 34'sh01DAC6705;
      5'd2:    r = 34'sh00FADBAFC;
      5'd3:    r = 34'sh007F56EA6;
      5'd4:    r = 34'sh003FEAB76;
      5'd5:    r = 34'sh001FFD55B;
      5'd6:    r = 34'sh000FFFAAA;
      5'd7:    r = 34'sh0007FFF55;
      5'd8:    r = 34'sh0003FFFEA;
      5'd9:    r = 34'sh0001FFFFD;
      5'd10:   r = 34'sh0000FFFFF;
      5'd11:   r = 34'sh00007FFFF;
      5'd12:   r = 34'sh00003FFFF;
      5'd13:   r = 34'sh00001FFFF;
      5'd14:   r = 34'sh00000FFFF;
      5'd15:   r = 34'sh000007FFF;
      5'd16:   r = 34'sh000003FFF;
      5'd17:   r = 34'sh000001FFF;
      5'd18:   r = 34'sh000000FFF;
      5'd19:   r = 34'sh0000007FF;
      5'd20:   r = 34'sh0000003FF;
      5'd21:   r = 34'sh0000001FF;
      5'd22:   r = 34'sh0000000FF;
      5'd23:   r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q30 radians to q13, round half away from zero, saturate to +-lim
  function automatic logic signed [15:0] q30_to_q13(input ang_t v, input logic [14:0] lim);
    logic [AW:0]  mag;
    logic [AW:0]  sum;
    logic [17:0]  r;
    logic [15:0]  rs;
    mag = v[AW-1] ? ((AW+1)'(0) - {v[AW-1], v}) : {v[AW-1], v};
    sum = mag + (AW+1)'(65536);
    r   = sum[AW:17];
    if (r > {3'b000, lim}) begin
      r = {3'b000, lim};
    end
    rs = r[15:0];
    return v[AW-1] ? $signed(16'd0 - rs) : $signed(rs);
  endfunction

endpackage
`default_nettype wire

### sv/qte_front.sv
// qte_front: products, sine of pitch, atan2 operands and the square root
// radicand, four register stages. Depends on qte_pkg.
`default_nettype none
module qte_front (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic               direction_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  output logic [60:0]             radicand_o,
  output qte_pkg::pass_t          pass_o
);
  import qte_pkg::*;

  logic signed [31:0] wx_q, yz_q, xz_q, wy_q, xy_q, wz_q, xx_q, yy_q, zz_q;
  pass_t              b_q, b_d, c_q, c_d, d_q;
  logic [29:0]        mag30_q, mag30_d;
  logic [59:0]        mag_sq;
  logic [60:0]        rad_q;

  always_comb begin
    logic signed [32:0] s;
    s = direction_i ? -(33'(yz_q) + 33'(wx_q)) : (33'(wx_q) - 33'(yz_q));
    b_d.sp      = {s, 1'b0};
    b_d.clamped = 1'b0;
    b_d.yaw_n   = direction_i ? (33'(wy_q) - 33'(xz_q)) : (33'(xz_q) + 33'(wy_q));
    b_d.roll_n  = direction_i ? (33'(wz_q) - 33'(xy_q)) : (33'(xy_q) + 33'(wz_q));
    b_d.yaw_x   = HALF_Q30 - 33'(xx_q) - 33'(yy_q);
    b_d.roll_x  = HALF_Q30 - 33'(xx_q) - 33'(zz_q);
  end

  always_comb begin
    logic [33:0] mag;
    mag         = b_q.sp[33] ? (34'd0 - b_q.sp) : b_q.sp;
    c_d         = b_q;
    c_d.clamped = (mag[33:30] != 4'd0);
    mag30_d     = c_d.clamped ? 30'd0 : mag[29:0];
  end

  // square of the pitch sine, full 60-bit product
  assign mag_sq = mag30_q * mag30_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q    <= quat_w_i * quat_x_i;
      yz_q    <= quat_y_i * quat_z_i;
      xz_q    <= quat_x_i * quat_z_i;
      wy_q    <= quat_w_i * quat_y_i;
      xy_q    <= quat_x_i * quat_y_i;
      wz_q    <= quat_w_i * quat_z_i;
      xx_q    <= quat_x_i * quat_x_i;
      yy_q    <= quat_y_i * quat_y_i;
      zz_q    <= quat_z_i * quat_z_i;
      b_q     <= b_d;
      c_q     <= c_d;
      mag30_q <= mag30_d;
      d_q     <= c_q;
      rad_q   <= (61'd1 << 60) - {1'b0, mag_sq};
    end
  end

  assign radicand_o = rad_q;
  assign pass_o     = d_q;

endmodule
`default_nettype wire

### sv/qte_sqrt_cell.sv
// qte_sqrt_cell: one restoring step of the integer square root.
// Depends on qte_pkg.
`default_nettype none
module qte_sqrt_cell (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [5:0]             shift_i,
  input  wire logic [qte_pkg::SQW-1:0] n_i,
  input  wire logic [qte_pkg::SQW-1:0] root_i,
  output logic [qte_pkg::SQW-1:0]     n_o,
  output logic [qte_pkg::SQW-1:0]     root_o
);
  import qte_pkg::*;

  logic [SQW-1:0] n_q, n_d, root_q, root_d;

  always_comb begin
    logic [SQW-1:0] bit_v;
    logic [SQW-1:0] t;
    bit_v = SQW'(1) << shift_i;
    t     = root_i + bit_v;
    if (n_i >= t) begin
      n_d    = n_i - t;
      root_d = (root_i >> 1) + bit_v;
    end else begin
      n_d    = n_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      root_q <= root_d;
    end
  end

  assign n_o    = n_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

### sv/qte_cordic_cell.sv
// qte_cordic_cell: one vectoring-mode cordic micro-rotation.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [4:0]    iter_i,
  input  wire qte_pkg::cw_t  x_i,
  input  wire qte_pkg::cw_t  y_i,
  input  wire qte_pkg::ang_t z_i,
  output qte_pkg::cw_t       x_o,
  output qte_pkg::cw_t       y_o,
  output qte_pkg::ang_t      z_o
);
  import qte_pkg::*;

  cw_t  x_q, x_d, y_q, y_d;
  ang_t z_q, z_d;

  always_comb begin
    cw_t dx;
    cw_t dy;
    dx = y_i >>> iter_i;
    dy = x_i >>> iter_i;
    if (!y_i[CW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_q30(iter_i);
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_q30(iter_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule
`default_nettype wire

### sv/qte_cordic_chain.sv
// qte_cordic_chain: atan2 by a half-plane pre-rotation stage and a row of
// cordic cells. Depends on qte_pkg and qte_cordic_cell.
`default_nettype none
module qte_cordic_chain (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire qte_pkg::cw_t  y_i,
  input  wire qte_pkg::cw_t  x_i,
  output qte_pkg::ang_t      z_o
);
  import qte_pkg::*;

  cw_t  xs [0:CORDIC_STEPS];
  cw_t  ys [0:CORDIC_STEPS];
  ang_t zs [0:CORDIC_STEPS];
  logic zero_q [0:CORDIC_STEPS];

  // left half-plane: turn by pi first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[CW-1]) begin
        zs[0] <= y_i[CW-1] ? -PI_Q30 : PI_Q30;
        xs[0] <= -x_i;
        ys[0] <= -y_i;
      end else begin
        zs[0] <= '0;
        xs[0] <= x_i;
        ys[0] <= y_i;
      end
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    qte_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .iter_i (5'(g)),
      .x_i    (xs[g]),
      .y_i    (ys[g]),
      .z_i    (zs[g]),
      .x_o    (xs[g+1]),
      .y_o    (ys[g+1]),
      .z_o    (zs[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[g+1] <= zero_q[g];
      end
    end
  end

  assign z_o = zero_q[CORDIC_STEPS] ? '0 : zs[CORDIC_STEPS];

endmodule
`default_nettype wire

### sv/quaternion_to_euler_angles.sv
// quaternion_to_euler_angles: top level, unit quaternion to pitch/yaw/roll.
// Depends on qte_pkg, qte_front, qte_sqrt_cell and qte_cordic_chain.
//
// usage
// - input channel in_valid_i/in_ready_o carries one request: quat_w/x/y/z,
//   signed q1.15
// - output channel out_valid_o/out_ready_i returns pitch (q2.13, +-pi/2),
//   yaw and roll (q3.13, +-pi) and pitch_clamped for every request, in order
// - config channel cfg_valid_i/cfg_direction_i writes the direction bit
//   (0 object-to-inertial, 1 inertial-to-object); cfg_ready_o is always high;
//   write it only while no request is in flight
// - fully pipelined: one request per cycle while the receiver takes results;
//   the path runs through the front stages, the 31-step square root row, the
//   pre-rotation stage, the 16-step cordic row and the output register
// - reset clears all valid bits and the direction bit; no clearing pass
// - receiver stall: the output register holds its request; the pipeline keeps
//   moving while its last stage is empty, so bubbles are squeezed out before
//   in_ready_o drops
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [14:0]      pitch_angle_o,
  output logic signed [15:0]      yaw_angle_o,
  output logic signed [15:0]      roll_angle_o,
  output logic                    pitch_clamped_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_direction_i
);
  import qte_pkg::*;

  logic                  direction_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  en;
  logic                  load;

  logic                  out_valid_q;
  logic signed [14:0]    pitch_q;
  logic signed [15:0]    yaw_q, roll_q;
  logic                  clamp_q;

  logic [60:0]           radicand;
  pass_t                 front_pass;
  pass_t                 pass_q [0:SQRT_STEPS-1];
  logic [SQW-1:0]        sq_n    [0:SQRT_STEPS];
  logic [SQW-1:0]        sq_root [0:SQRT_STEPS];
  pflag_t                flag_q  [0:CORDIC_STEPS];
  ang_t                  z_pitch, z_yaw, z_roll;
  pass_t                 tail;

  // output register takes a new request when empty or being drained
  assign load       = !out_valid_q || out_ready_i;
  // pipeline moves when its last stage can leave or holds nothing
  assign en         = load || !vld_q[PIPE_DEPTH-1];
  assign in_ready_o = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
    end else if (cfg_valid_i) begin
      direction_q <= cfg_direction_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
      end
      if (load) begin
        out_valid_q <= vld_q[PIPE_DEPTH-1];
      end
    end
  end

  // products, sine of pitch, atan2 operands, radicand
  qte_front u_front (
    .clk_i       (clk_i),
    .en_i        (en),
    .direction_i (direction_q),
    .quat_w_i    (quat_w_i),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .radicand_o  (radicand),
    .pass_o      (front_pass)
  );

  // cosine of pitch: one root bit per cell
  assign sq_n[0]    = SQW'(radicand);
  assign sq_root[0] = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    qte_sqrt_cell u_sqrt (
      .clk_i   (clk_i),
      .en_i    (en),
      .shift_i (6'(2 * (SQRT_STEPS - 1 - g))),
      .n_i     (sq_n[g]),
      .root_i  (sq_root[g]),
      .n_o     (sq_n[g+1]),
      .root_o  (sq_root[g+1])
    );
    // operands for yaw and roll ride alongside the root
    always_ff @(posedge clk_i) begin
      if (en) begin
        pass_q[g] <= (g == 0) ? front_pass : pass_q[(g == 0) ? 0 : g - 1];
      end
    end
  end

  assign tail = pass_q[SQRT_STEPS-1];

  qte_cordic_chain u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(tail.sp)),
    .x_i   (CW'({1'b0, sq_root[SQRT_STEPS][30:0]})),
    .z_o   (z_pitch)
  );

  qte_cordic_chain u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(tail.yaw_n)),
    .x_i   (CW'(tail.yaw_x)),
    .z_o   (z_yaw)
  );

  qte_cordic_chain u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(tail.roll_n)),
    .x_i   (CW'(tail.roll_x)),
    .z_o   (z_roll)
  );

  // saturation flag and sign follow the cordic row
  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_q[0].clamped <= tail.clamped;
      flag_q[0].neg     <= tail.sp[33];
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_flag
    always_ff @(posedge clk_i) begin
      if (en) begin
        flag_q[g+1] <= flag_q[g];
      end
    end
  end

  // rounding to q13 into the output register
  always_ff @(posedge clk_i) begin
    logic signed [15:0] p;
    if (load && vld_q[PIPE_DEPTH-1]) begin
      if (flag_q[CORDIC_STEPS].clamped) begin
        p = flag_q[CORDIC_STEPS].neg ? -$signed({1'b0, PITCH_MAX_Q13})
                                     :  $signed({1'b0, PITCH_MAX_Q13});
      end else begin
        p = q30_to_q13(z_pitch, PITCH_MAX_Q13);
      end
      pitch_q <= p[14:0];
      yaw_q   <= q30_to_q13(z_yaw, ANGLE_MAX_Q13);
      roll_q  <= q30_to_q13(z_roll, ANGLE_MAX_Q13);
      clamp_q <= flag_q[CORDIC_STEPS].clamped;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pitch_angle_o   = pitch_q;
  assign yaw_angle_o     = yaw_q;
  assign roll_angle_o    = roll_q;
  assign pitch_clamped_o = clamp_q;

endmodule
`default_nettype wire

### sv/qte_checker.sv
// qte_checker: port-level assertions for quaternion_to_euler_angles, bound
// to the top level. Depends on nothing beyond the top level's ports.
`default_nettype none
module qte_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [14:0] pitch_angle_o,
  input wire logic signed [15:0] yaw_angle_o,
  input wire logic               pitch_clamped_o
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pitch_angle_o) && $stable(yaw_angle_o))
    else $error("stalled result changed");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_angle_o <= 15'sd12868) && (pitch_angle_o >= -15'sd12868))
    else $error("pitch beyond pi/2");

  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pitch_clamped_o |->
      (pitch_angle_o == 15'sd12868) || (pitch_angle_o == -15'sd12868))
    else $error("clamped pitch not at pi/2");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yaw_angle_o <= 16'sd25736) && (yaw_angle_o >= -16'sd25736))
    else $error("yaw beyond pi");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);
`default_nettype wire
